FILE: hdl/mtmq_pkg.sv
`default_nettype none
package mtmq_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  source;
    logic [15:0] count;
    logic [15:0] tag;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic exec;
  } cmd_t;

  localparam logic [1:0] FN_ARRIVE = 2'd0;
  localparam logic [1:0] FN_RECV   = 2'd1;
  localparam logic [1:0] FN_END    = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [1:0] CFG_OWN_RANK   = 2'd0;
  localparam logic [1:0] CFG_WORLD_SIZE = 2'd1;
  localparam logic [1:0] CFG_WILDCARD   = 2'd2;

  localparam logic [3:0] ST_STORED    = 4'd0;
  localparam logic [3:0] ST_FOUND     = 4'd1;
  localparam logic [3:0] ST_COMPLETED = 4'd2;
  localparam logic [3:0] ST_PENDING   = 4'd3;
  localparam logic [3:0] ST_REMOTE    = 4'd4;
  localparam logic [3:0] ST_SELF      = 4'd5;
  localparam logic [3:0] ST_NORANK    = 4'd6;
  localparam logic [3:0] ST_FULL      = 4'd7;
  localparam logic [3:0] ST_ENDACK    = 4'd8;

  function automatic logic desc_match(entry_t a, entry_t b, logic [15:0] wc);
    logic eq;
    eq = (a.kind == b.kind) && (a.source == b.source) && (a.count == b.count);
    return eq && ((a.tag == wc) || (b.tag == wc) || (a.tag == b.tag));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/mtmq_ctrl.sv
`default_nettype none
module mtmq_ctrl
  import mtmq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_CMP;
      S_CMP:  state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign cmd_o.load = (state_q == S_IDLE) && start;
  assign cmd_o.cmp  = (state_q == S_CMP);
  assign cmd_o.exec = (state_q == S_EXEC);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_EXEC))
    else $error("result strobe without execute step");
  a_cmp_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |=> (state_q == S_EXEC))
    else $error("compare not followed by execute");

endmodule
`default_nettype wire

FILE: hdl/mtmq_dpath.sv
`default_nettype none
module mtmq_dpath
  import mtmq_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int RANKS       = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  input  wire  [1:0]  func_i,
  input  wire  [1:0]  msg_kind_i,
  input  wire  [3:0]  source_i,
  input  wire  [15:0] byte_count_i,
  input  wire  [15:0] tag_i,
  input  wire  [15:0] payload_handle_i,
  output logic [3:0]  status_o,
  output logic [15:0] match_handle_o,
  output logic [3:0]  match_source_o,
  output logic [15:0] match_tag_o,
  output logic [15:0] match_count_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [3:0]  own_rank_q;
  logic [4:0]  world_size_q;
  logic [15:0] wildcard_q;

  logic [1:0] func_q;
  entry_t     item_q;
  entry_t     tbl_q [TABLE_DEPTH];
  logic [CW-1:0] used_q;
  entry_t     pend_q;
  logic       pend_valid_q;
  logic [RANKS-1:0] ended_q;

  logic [TABLE_DEPTH-1:0] match_q, match_d, oh, ge;
  logic pend_hit_q;
  logic hit, rank_ended;
  entry_t found;

  logic do_append, do_remove;
  logic [3:0] res_status_d;
  entry_t res_d;
  logic pend_clr, pend_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_rank_q   <= 4'd0;
      world_size_q <= 5'd16;
      wildcard_q   <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_RANK:   own_rank_q   <= cfg_data_i[3:0];
        CFG_WORLD_SIZE: world_size_q <= cfg_data_i[4:0];
        CFG_WILDCARD:   wildcard_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q        <= func_i;
      item_q.kind   <= msg_kind_i;
      item_q.source <= source_i;
      item_q.count  <= byte_count_i;
      item_q.tag    <= tag_i;
      item_q.handle <= payload_handle_i;
    end
  end

  // parallel compare against every live entry
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      match_d[j] = (CW'(j) < used_q) && desc_match(tbl_q[j], item_q, wildcard_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      match_q    <= match_d;
      pend_hit_q <= pend_valid_q && desc_match(item_q, pend_q, wildcard_q);
    end
  end

  // oldest match and the entries at or above it
  assign hit = |match_q;
  assign oh  = match_q & (~match_q + TABLE_DEPTH'(1));
  assign ge  = ~(oh - TABLE_DEPTH'(1));

  always_comb begin
    found = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      found = found | (tbl_q[j] & {$bits(entry_t){oh[j]}});
    end
    rank_ended = 1'b0;
    for (int r = 0; r < RANKS; r++) begin
      rank_ended = rank_ended | (ended_q[r] && (32'(item_q.source) == r));
    end
  end

  always_comb begin
    do_append    = 1'b0;
    do_remove    = 1'b0;
    pend_clr     = 1'b0;
    pend_set     = 1'b0;
    res_status_d = ST_NORANK;
    res_d        = '0;
    case (func_q)
      FN_ARRIVE: begin
        if (pend_hit_q) begin
          pend_clr     = 1'b1;
          res_status_d = ST_COMPLETED;
          res_d        = item_q;
        end else if (used_q == DEPTH_C) begin
          res_status_d = ST_FULL;
        end else begin
          do_append    = 1'b1;
          res_status_d = ST_STORED;
        end
      end
      FN_RECV: begin
        if (item_q.source == own_rank_q) begin
          res_status_d = ST_SELF;
        end else if ({1'b0, item_q.source} >= world_size_q) begin
          res_status_d = ST_NORANK;
        end else if (hit) begin
          do_remove    = 1'b1;
          res_status_d = ST_FOUND;
          res_d        = found;
        end else if (rank_ended) begin
          res_status_d = ST_REMOTE;
        end else begin
          pend_set     = 1'b1;
          res_status_d = ST_PENDING;
        end
      end
      FN_END: begin
        if (pend_valid_q && (pend_q.source == item_q.source)) begin
          pend_clr     = 1'b1;
          res_status_d = ST_REMOTE;
        end else begin
          res_status_d = ST_ENDACK;
        end
      end
      default: res_status_d = ST_NORANK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      pend_valid_q <= 1'b0;
      ended_q      <= '0;
    end else if (cmd_i.exec) begin
      if (do_append) used_q <= used_q + CW'(1);
      if (do_remove) used_q <= used_q - CW'(1);
      if (pend_clr)  pend_valid_q <= 1'b0;
      if (pend_set)  pend_valid_q <= 1'b1;
      if (func_q == FN_END) begin
        for (int r = 0; r < RANKS; r++) begin
          if (32'(item_q.source) == r) ended_q[r] <= 1'b1;
        end
      end
    end
  end

  // compact on removal, append at the tail
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (do_remove && ge[j]) begin
          if (j < TABLE_DEPTH - 1) tbl_q[j] <= tbl_q[(j + 1) % TABLE_DEPTH];
        end else if (do_append && (used_q == CW'(j))) begin
          tbl_q[j] <= item_q;
        end
      end
      // drop the handle of a posted receive
      if (pend_set) begin
        pend_q <= {item_q.kind, item_q.source, item_q.count, item_q.tag, 16'd0};
      end
      status_o       <= res_status_d;
      match_handle_o <= res_d.handle;
      match_source_o <= res_d.source;
      match_tag_o    <= res_d.tag;
      match_count_o  <= res_d.count;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/message_tag_match_queue_core.sv
`default_nettype none
// Message tag matching engine with an ordered table of unexpected arrivals.
// Command channel: drive func_i and the item fields with start high; the
// command is taken at the edge where start is high and busy is low.
// func_i: arrival, post receive or source-ended notice.
// Result: one beat per command, on status_o and the match_* ports for one
// cycle while result_valid_o is high. The receiver cannot stall it.
// Steps: load registers the item, compare registers the table matches, then
// decide/compact/append registers the result; no new command meanwhile.
// Configuration: cfg_we_i with cfg_idx_i (0 own rank, 1 world size,
// 2 wildcard tag) and cfg_data_i, written at the edge. The user must
// write only while idle; the block itself does not enforce it.
// Reset: table empty, no pending receive, no ended sources, own rank 0,
// world size 16, wildcard tag 0. No clearing pass is needed.
module message_tag_match_queue_core
  import mtmq_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int RANKS       = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  func_i,
  input  wire  [1:0]  msg_kind_i,
  input  wire  [3:0]  source_i,
  input  wire  [15:0] byte_count_i,
  input  wire  [15:0] tag_i,
  input  wire  [15:0] payload_handle_i,
  output logic        result_valid_o,
  output logic [3:0]  status_o,
  output logic [15:0] match_handle_o,
  output logic [3:0]  match_source_o,
  output logic [15:0] match_tag_o,
  output logic [15:0] match_count_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);

  cmd_t cmd;

  mtmq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (result_valid_o),
    .cmd_o  (cmd)
  );

  mtmq_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RANKS       (RANKS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .msg_kind_i       (msg_kind_i),
    .source_i         (source_i),
    .byte_count_i     (byte_count_i),
    .tag_i            (tag_i),
    .payload_handle_i (payload_handle_i),
    .status_o         (status_o),
    .match_handle_o   (match_handle_o),
    .match_source_o   (match_source_o),
    .match_tag_o      (match_tag_o),
    .match_count_o    (match_count_o)
  );

endmodule
`default_nettype wire

FILE: test/match_checker.sv
`timescale 1ns / 1ps
module match_checker
  import mtmq_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  input  wire         busy,
  input  wire  [1:0]  func_i,
  input  wire  [1:0]  msg_kind_i,
  input  wire  [3:0]  source_i,
  input  wire  [15:0] byte_count_i,
  input  wire  [15:0] tag_i,
  input  wire  [15:0] payload_handle_i,
  input  wire         result_valid_o,
  input  wire  [3:0]  status_o,
  input  wire  [15:0] match_handle_o,
  input  wire  [3:0]  match_source_o,
  input  wire  [15:0] match_tag_o,
  input  wire  [15:0] match_count_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  output int          errors,
  output int          outstanding
);

  localparam int DEPTH = 32;
  localparam int NRANK = 16;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] handle;
    logic [3:0]  source;
    logic [15:0] tag;
    logic [15:0] count;
  } verdict_t;

  entry_t     unexpected_q[$];
  entry_t     waiting_recv;
  logic       waiting_ok;
  logic [NRANK-1:0] ended;
  logic [3:0]  my_rank;
  logic [4:0]  n_ranks;
  logic [15:0] wild;
  verdict_t   verdicts_q[$];

  assign outstanding = verdicts_q.size();

  function automatic logic same_desc(entry_t a, entry_t b);
    if (a.kind != b.kind || a.source != b.source || a.count != b.count) return 1'b0;
    return a.tag == wild || b.tag == wild || a.tag == b.tag;
  endfunction

  function automatic verdict_t with_msg(logic [3:0] st, entry_t m);
    verdict_t v;
    v.status = st; v.handle = m.handle; v.source = m.source;
    v.tag = m.tag; v.count = m.count;
    return v;
  endfunction

  task automatic apply_command(logic [1:0] fn, entry_t it);
    verdict_t v;
    int hit;
    v = '0;
    hit = -1;
    if (fn == FN_ARRIVE) begin
      if (waiting_ok && same_desc(it, waiting_recv)) begin
        waiting_ok = 1'b0;
        v = with_msg(ST_COMPLETED, it);
      end else if (unexpected_q.size() >= DEPTH) begin
        v.status = ST_FULL;
      end else begin
        unexpected_q.push_back(it);
        v.status = ST_STORED;
      end
    end else if (fn == FN_RECV) begin
      if (it.source == my_rank) v.status = ST_SELF;
      else if ({1'b0, it.source} >= n_ranks) v.status = ST_NORANK;
      else begin
        foreach (unexpected_q[i])
          if (hit < 0 && same_desc(unexpected_q[i], it)) hit = i;
        if (hit >= 0) begin
          v = with_msg(ST_FOUND, unexpected_q[hit]);
          unexpected_q.delete(hit);
        end else if (ended[it.source]) begin
          v.status = ST_REMOTE;
        end else begin
          waiting_recv = it;
          waiting_recv.handle = '0;
          waiting_ok = 1'b1;
          v.status = ST_PENDING;
        end
      end
    end else if (fn == FN_END) begin
      ended[it.source] = 1'b1;
      if (waiting_ok && waiting_recv.source == it.source) begin
        waiting_ok = 1'b0;
        v.status = ST_REMOTE;
      end else v.status = ST_ENDACK;
    end else begin
      v.status = ST_NORANK;
    end
    verdicts_q.push_back(v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t it;
    verdict_t got, want;
    if (!rst_ni) begin
      unexpected_q.delete();
      verdicts_q.delete();
      waiting_ok = 1'b0;
      waiting_recv = '0;
      ended = '0;
      my_rank = 4'd0;
      n_ranks = 5'd16;
      wild = 16'd0;
      errors = 0;
    end else begin
      if (result_valid_o) begin
        got = '{status_o, match_handle_o, match_source_o, match_tag_o, match_count_o};
        if (verdicts_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, actual %h", $time, got);
        end else begin
          want = verdicts_q.pop_front();
          if (got !== want) begin
            errors++;
            $display({"%0t: status exp %0d act %0d | handle exp %h act %h",
                      " | src exp %0d act %0d | tag exp %h act %h",
                      " | count exp %h act %h"},
                     $time, want.status, got.status, want.handle, got.handle,
                     want.source, got.source, want.tag, got.tag, want.count, got.count);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_RANK:   my_rank = cfg_data_i[3:0];
          CFG_WORLD_SIZE: n_ranks = cfg_data_i[4:0];
          CFG_WILDCARD:   wild = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        it = '{msg_kind_i, source_i, byte_count_i, tag_i, payload_handle_i};
        apply_command(func_i, it);
      end
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mtmq_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  func_i = '0;
  logic [1:0]  msg_kind_i = '0;
  logic [3:0]  source_i = '0;
  logic [15:0] byte_count_i = '0;
  logic [15:0] tag_i = '0;
  logic [15:0] payload_handle_i = '0;
  logic        result_valid_o;
  logic [3:0]  status_o;
  logic [15:0] match_handle_o, match_tag_o, match_count_o;
  logic [3:0]  match_source_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int errors, outstanding;

  // small pools so arrivals and receives meet often
  logic [15:0] count_pool[4] = '{16'd0, 16'd64, 16'hFFFF, 16'd8};
  logic [15:0] tag_pool[4] = '{16'd0, 16'd7, 16'hFFFF, 16'd300};

  always #5 clk_i = ~clk_i;

  message_tag_match_queue_core dut (.*);
  match_checker checker_i (.*);

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic issue(logic [1:0] fn, logic [1:0] k, logic [3:0] s,
                       logic [15:0] c, logic [15:0] t, logic [15:0] h, bit gap);
    func_i = fn; msg_kind_i = k; source_i = s;
    byte_count_i = c; tag_i = t; payload_handle_i = h;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    start = 1'b0;
    if (gap) idle_gap();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    while (outstanding != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_item();
    logic [1:0] fn;
    int r;
    r = $urandom_range(0, 99);
    fn = (r < 50) ? FN_ARRIVE : (r < 88) ? FN_RECV : (r < 97) ? FN_END : FN_UNUSED;
    issue(fn, $urandom_range(0, 1) ? 2'd0 : 2'($urandom),
          ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5)),
          ($urandom_range(0, 9) == 0) ? 16'($urandom) : count_pool[$urandom_range(0, 3)],
          ($urandom_range(0, 9) == 0) ? 16'($urandom) : tag_pool[$urandom_range(0, 3)],
          16'($urandom), 1'b1);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: defaults, own rank 0
    issue(FN_RECV, 2'd0, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);       // self
    issue(FN_ARRIVE, 2'd3, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(FN_RECV, 2'd3, 4'd15, 16'hFFFF, 16'd0, 16'd0, 1'b0);   // wildcard take
    issue(FN_RECV, 2'd1, 4'd2, 16'd5, 16'd9, 16'd0, 1'b0);       // pending
    issue(FN_RECV, 2'd1, 4'd2, 16'd5, 16'd10, 16'd0, 1'b0);      // replace pending
    issue(FN_ARRIVE, 2'd1, 4'd2, 16'd5, 16'd10, 16'hABCD, 1'b0); // completes
    issue(FN_RECV, 2'd2, 4'd3, 16'd1, 16'd1, 16'd0, 1'b0);
    issue(FN_END, 2'd0, 4'd3, 16'd0, 16'd0, 16'd0, 1'b0);        // fails pending
    issue(FN_RECV, 2'd2, 4'd3, 16'd1, 16'd1, 16'd0, 1'b0);       // remote finished
    issue(FN_END, 2'd0, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);        // ack
    issue(FN_UNUSED, 2'd0, 4'd1, 16'd0, 16'd0, 16'd0, 1'b0);     // unused code
    for (int i = 0; i < 33; i++)                                 // fill past full
      issue(FN_ARRIVE, 2'd0, 4'd4, 16'(i), 16'd1, 16'(i), 1'b0);
    for (int i = 0; i < 3; i++)                                  // remove head and middle
      issue(FN_RECV, 2'd0, 4'd4, 16'(i * 7), 16'd1, 16'd0, 1'b0);
    write_reg(CFG_WORLD_SIZE, 16'd4);
    write_reg(CFG_OWN_RANK, 16'd15);
    issue(FN_RECV, 2'd0, 4'd4, 16'd1, 16'd1, 16'd0, 1'b0);       // no rank
    issue(FN_RECV, 2'd0, 4'd15, 16'd1, 16'd1, 16'd0, 1'b0);      // self first
    write_reg(CFG_WILDCARD, 16'hFFFF);
    write_reg(CFG_WORLD_SIZE, 16'd16);
    for (int i = 0; i < 3; i++)                                  // drain table
      for (int j = 0; j < 32; j++)
        issue(FN_RECV, 2'd0, 4'd4, 16'(j), 16'hFFFF, 16'd0, 1'b0);
    // random phases over several settings
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_OWN_RANK, (p == 0) ? 16'd0 : 16'($urandom_range(0, 15)));
      write_reg(CFG_WORLD_SIZE, (p == 1) ? 16'd1 : (p == 2) ? 16'd16 :
                16'($urandom_range(2, 16)));
      write_reg(CFG_WILDCARD, (p == 3) ? 16'hFFFF : tag_pool[$urandom_range(0, 3)]);
      for (int i = 0; i < 120; i++) random_item();
    end
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
hdl/mtmq_pkg.sv
hdl/mtmq_ctrl.sv
hdl/mtmq_dpath.sv
hdl/message_tag_match_queue_core.sv
test/match_checker.sv
test/testbench.sv
